// ===== rtl/core/chained_hash_counter_mtf_assert.svh =====
// Assertion macros for the chained hash counter.
// Expects clk and rst_n in the scope of each use.
`ifndef CHAINED_HASH_COUNTER_MTF_ASSERT_SVH
`define CHAINED_HASH_COUNTER_MTF_ASSERT_SVH

// Same-cycle implication.
`define CHM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CHM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Invariant on every clock edge out of reset.
`define CHM_ASSERT_ALW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

// ===== rtl/core/chm_pkg.sv =====
// Shared constants and the cell control struct of the chained hash counter.
// No dependencies.
package chm_pkg;

  localparam int BUCKETS_DEF = 4;
  localparam int DEPTH_DEF   = 8;

  localparam int KEY_W     = 32;
  localparam int CNT_W     = 4;
  localparam int BUCKET_OW = 2;
  localparam int POS_OW    = 3;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 4'd10;

  // Broadcast from the top level to every cell during the update cycle.
  typedef struct packed {
    logic             upd;
    logic             hit;
    logic             move;
    logic             append;
    logic [CNT_W-1:0] cnt_new;
  } chm_ctl_t;

endpackage

// ===== rtl/core/chm_hash.sv =====
// Bucket index unit: key modulo the bucket count.
// Depends on chm_pkg. Power-of-two counts are a mask, others a reciprocal stage.
module chm_hash
  import chm_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF
) (
  input  logic                       clk,
  input  logic                       load_i,
  input  logic [KEY_W-1:0]           key_i,
  input  logic [KEY_W-1:0]           key_r_i,
  output logic [$clog2(BUCKETS)-1:0] bucket_o
);

  localparam int BW = $clog2(BUCKETS);

  if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_mask
    assign bucket_o = key_i[BW-1:0];
  end else begin : g_recip
    // q_est = floor(key * M / 2^N) is q or q-1, so the remainder stays below 2B.
    localparam int          L     = BW - 1;
    localparam int          N     = KEY_W + L;
    localparam int          RW    = BW + 1;
    localparam logic [63:0] RECIP = (64'd1 << N) / BUCKETS;
    localparam logic [KEY_W-1:0] RECIP_W = RECIP[KEY_W-1:0];
    localparam logic [RW-1:0]    B_RW    = RW'(BUCKETS);

    logic [63:0]   prod;
    logic [RW-1:0] qlo_r;
    logic [RW-1:0] qb;
    logic [RW-1:0] rem;

    assign prod = 64'(key_i) * 64'(RECIP_W);

    always_ff @(posedge clk) begin
      if (load_i) begin
        qlo_r <= prod[N +: RW];
      end
    end

    assign qb  = RW'(qlo_r * B_RW);
    assign rem = key_r_i[RW-1:0] - qb;

    always_comb begin
      if (rem >= B_RW) begin
        bucket_o = BW'(rem - B_RW);
      end else begin
        bucket_o = rem[BW-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/chm_cell.sv =====
// One slot position of every bucket: key/count storage, compare and shift.
// Depends on chm_pkg.
module chm_cell
  import chm_pkg::*;
#(
  parameter int IDX         = 0,
  parameter int BUCKETS     = BUCKETS_DEF,
  parameter int CHAIN_DEPTH = DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rd_en_i,
  input  logic [$clog2(BUCKETS)-1:0]       rd_addr_i,
  input  logic [$clog2(BUCKETS)-1:0]       wr_addr_i,
  input  logic [KEY_W-1:0]                 key_i,
  input  logic [$clog2(CHAIN_DEPTH+1)-1:0] fill_i,
  input  chm_ctl_t                         ctl_i,
  input  logic [KEY_W-1:0]                 prev_key_i,
  input  logic [CNT_W-1:0]                 prev_cnt_i,
  input  logic                             found_i,
  output logic [KEY_W-1:0]                 key_o,
  output logic [CNT_W-1:0]                 cnt_o,
  output logic                             found_o,
  output logic                             first_o
);

  localparam int FW = $clog2(CHAIN_DEPTH + 1);
  localparam logic [FW-1:0] IDX_F = FW'(IDX);

  logic [KEY_W-1:0] key_mem [BUCKETS];
  logic [CNT_W-1:0] cnt_mem [BUCKETS];
  logic [KEY_W-1:0] rd_key_r;
  logic [CNT_W-1:0] rd_cnt_r;

  logic             match;
  logic             we;
  logic [KEY_W-1:0] wkey;
  logic [CNT_W-1:0] wcnt;

  always_ff @(posedge clk) begin
    if (rd_en_i) begin
      rd_key_r <= key_mem[rd_addr_i];
      rd_cnt_r <= cnt_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[wr_addr_i] <= wkey;
      cnt_mem[wr_addr_i] <= wcnt;
    end
  end

  assign match   = (IDX_F < fill_i) && (rd_key_r == key_i);
  assign first_o = match && !found_i;
  assign found_o = found_i || match;
  assign key_o   = rd_key_r;
  assign cnt_o   = rd_cnt_r;

  // Cells up to the hit slot have found_i low; on a move they take the previous slot's entry, slot 0 the key.
  always_comb begin
    we   = 1'b0;
    wkey = key_i;
    wcnt = '0;
    if (ctl_i.upd) begin
      if (ctl_i.move && !found_i) begin
        we = 1'b1;
        if (IDX != 0) begin
          wkey = prev_key_i;
          wcnt = prev_cnt_i;
        end
      end else if (ctl_i.hit && !ctl_i.move && first_o) begin
        we   = 1'b1;
        wkey = rd_key_r;
        wcnt = ctl_i.cnt_new;
      end else if (ctl_i.append && (fill_i == IDX_F)) begin
        we = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/chained_hash_counter_mtf.sv =====
// Chained hash counter with move-to-front; top level over chm_hash and chm_cell.
// Flow: an accepted key reads the cell memories (after the ST_HASH reciprocal stage
//   for a non-power-of-two BUCKETS), ST_LOOK compares and updates, and the result is registered.
// No new transaction is taken while busy; busy covers the cell lookup
//   and update, which must finish before the next read of the cell memories.
// Reset: synchronous rst_n clears the FSM, out_valid and bucket fill counts, and sets count_limit to 10.
// The result strobe is single-cycle and cannot be stalled by the receiver.
`include "chained_hash_counter_mtf_assert.svh"

module chained_hash_counter_mtf
  import chm_pkg::*;
#(
  parameter int BUCKETS     = BUCKETS_DEF,
  parameter int CHAIN_DEPTH = DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 start,
  output logic                 busy,
  input  logic [KEY_W-1:0]     in_key,
  // configuration channel (count_limit)
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CNT_W-1:0]     cfg_data,
  // result channel
  output logic                 out_valid,
  output logic [BUCKET_OW-1:0] out_bucket,
  output logic                 out_found,
  output logic [CNT_W-1:0]     out_count_after,
  output logic [POS_OW-1:0]    out_position,
  output logic                 out_moved_front,
  output logic                 out_full_drop
);

  localparam int BW = $clog2(BUCKETS);
  localparam int PW = $clog2(CHAIN_DEPTH);
  localparam int FW = $clog2(CHAIN_DEPTH + 1);
  localparam logic HASH_STAGE = ((BUCKETS & (BUCKETS - 1)) != 0);
  localparam logic [FW-1:0] DEPTH_F = FW'(CHAIN_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_LOOK
  } state_t;

  state_t           state_r;
  logic [KEY_W-1:0] key_r;
  logic [BW-1:0]    bucket_r;
  logic [CNT_W-1:0] limit_r;
  logic [FW-1:0]    fill_r [BUCKETS];

  logic             accept;
  logic             rd_en;
  logic [BW-1:0]    hash_bucket;
  logic [FW-1:0]    fill_cur;

  // Cell row: found ripples from slot 0 upward, read data feeds the next slot.
  logic [KEY_W-1:0]       cell_key [CHAIN_DEPTH];
  logic [CNT_W-1:0]       cell_cnt [CHAIN_DEPTH];
  logic [CHAIN_DEPTH:0]   found_c;
  logic [CHAIN_DEPTH-1:0] first_v;

  chm_ctl_t         ctl;
  logic             hit;
  logic [PW-1:0]    hit_pos;
  logic [CNT_W-1:0] hit_cnt;
  logic [CNT_W-1:0] cnt_inc;
  logic             at_limit;
  logic             drop;
  logic [7:0]       pos_wide;
  logic [7:0]       bucket_wide;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Cell memories are read at the accept edge for a masked bucket, or after
  // the reciprocal stage otherwise.
  assign rd_en = (accept && !HASH_STAGE) || (state_r == ST_HASH);

  chm_hash #(
    .BUCKETS (BUCKETS)
  ) u_hash (
    .clk      (clk),
    .load_i   (accept),
    .key_i    (in_key),
    .key_r_i  (key_r),
    .bucket_o (hash_bucket)
  );

  for (genvar g = 0; g < CHAIN_DEPTH; g++) begin : g_cell
    logic [KEY_W-1:0] prev_key;
    logic [CNT_W-1:0] prev_cnt;

    if (g == 0) begin : g_head
      assign prev_key = '0;
      assign prev_cnt = '0;
    end else begin : g_body
      assign prev_key = cell_key[g-1];
      assign prev_cnt = cell_cnt[g-1];
    end

    chm_cell #(
      .IDX         (g),
      .BUCKETS     (BUCKETS),
      .CHAIN_DEPTH (CHAIN_DEPTH)
    ) u_cell (
      .clk        (clk),
      .rd_en_i    (rd_en),
      .rd_addr_i  (hash_bucket),
      .wr_addr_i  (bucket_r),
      .key_i      (key_r),
      .fill_i     (fill_cur),
      .ctl_i      (ctl),
      .prev_key_i (prev_key),
      .prev_cnt_i (prev_cnt),
      .found_i    (found_c[g]),
      .key_o      (cell_key[g]),
      .cnt_o      (cell_cnt[g]),
      .found_o    (found_c[g+1]),
      .first_o    (first_v[g])
    );
  end

  assign found_c[0] = 1'b0;
  assign hit        = found_c[CHAIN_DEPTH];
  assign fill_cur   = fill_r[bucket_r];

  // first_v is one-hot on a hit, so slot number and count are plain OR muxes.
  always_comb begin
    hit_pos = '0;
    hit_cnt = '0;
    for (int i = 0; i < CHAIN_DEPTH; i++) begin
      if (first_v[i]) begin
        hit_pos = hit_pos | PW'(i);
        hit_cnt = hit_cnt | cell_cnt[i];
      end
    end
  end

  assign cnt_inc  = hit_cnt + 1'b1;
  assign at_limit = (cnt_inc == limit_r);

  always_comb begin
    ctl.upd     = (state_r == ST_LOOK);
    ctl.hit     = hit;
    // A hit at the head at the limit only clears its count.
    ctl.move    = hit && at_limit && (hit_pos != '0);
    ctl.append  = !hit && (fill_cur < DEPTH_F);
    ctl.cnt_new = at_limit ? '0 : cnt_inc;
  end

  assign drop = !hit && !ctl.append;

  always_comb begin
    if (hit) begin
      pos_wide = 8'(hit_pos);
    end else if (ctl.append) begin
      pos_wide = 8'(fill_cur);
    end else begin
      pos_wide = '0;
    end
  end

  assign bucket_wide = 8'(bucket_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BUCKETS; i++) begin
        fill_r[i] <= '0;
      end
    end else if (ctl.upd && ctl.append) begin
      fill_r[bucket_r] <= fill_cur + 1'b1;
    end
  end

  // Bucket index is captured with the cell read.
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_key;
    end
    if (rd_en) begin
      bucket_r <= hash_bucket;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= HASH_STAGE ? ST_HASH : ST_LOOK;
          end
        end
        ST_HASH: begin
          state_r <= ST_LOOK;
        end
        ST_LOOK: begin
          state_r         <= ST_IDLE;
          out_valid       <= 1'b1;
          out_bucket      <= bucket_wide[BUCKET_OW-1:0];
          out_found       <= hit;
          out_count_after <= hit ? ctl.cnt_new : '0;
          out_position    <= pos_wide[POS_OW-1:0];
          out_moved_front <= ctl.move;
          out_full_drop   <= drop;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks (the match row is only meaningful while a lookup is in progress)
  `CHM_ASSERT_IMP(a_out_after_look, out_valid, $past(state_r == ST_LOOK), "result without lookup")
  `CHM_ASSERT_NXT(a_accept_busy, accept, busy, "busy low after accepted transaction")
  `CHM_ASSERT_IMP(a_first_onehot, state_r == ST_LOOK, $onehot0(first_v), "multiple first matches")
  `CHM_ASSERT_IMP(a_fill_bound, state_r == ST_LOOK, fill_cur <= DEPTH_F, "bucket fill over depth")
  `CHM_ASSERT_IMP(a_flags_excl, out_valid, !(out_full_drop && (out_found || out_moved_front)),
                  "drop flagged with hit or move")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for chained_hash_counter_mtf: directed lookups, then
// random key traffic over several count_limit settings, against a shadow table.
// Depends on chm_pkg and the block's RTL.
module tb_top;
  import chm_pkg::*;

  localparam int NB          = BUCKETS_DEF;
  localparam int ND          = DEPTH_DEF;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 175;
  localparam int DRAIN_GUARD = 1000;  // cycles allowed for results to drain
  localparam int LAT_CUSHION = 4;     // extra wait after the last result is back

  // One result transaction, packed in port order for a single compare.
  typedef struct packed {
    logic [BUCKET_OW-1:0] bucket;
    logic                 found;
    logic [CNT_W-1:0]     count_after;
    logic [POS_OW-1:0]    position;
    logic                 moved_front;
    logic                 full_drop;
  } lookup_res_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [KEY_W-1:0]     in_key;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CNT_W-1:0]     cfg_data;
  logic                 out_valid;
  logic [BUCKET_OW-1:0] out_bucket;
  logic                 out_found;
  logic [CNT_W-1:0]     out_count_after;
  logic [POS_OW-1:0]    out_position;
  logic                 out_moved_front;
  logic                 out_full_drop;

  chained_hash_counter_mtf #(
    .BUCKETS     (NB),
    .CHAIN_DEPTH (ND)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_key          (in_key),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_bucket      (out_bucket),
    .out_found       (out_found),
    .out_count_after (out_count_after),
    .out_position    (out_position),
    .out_moved_front (out_moved_front),
    .out_full_drop   (out_full_drop)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Shadow of the hash table: per-bucket rows of key/count, fill per bucket,
  // and the current count_limit. Only slots below the fill are ever read.
  logic [KEY_W-1:0] shadow_key [NB][ND];
  logic [CNT_W-1:0] shadow_cnt [NB][ND];
  int               shadow_fill [NB];
  logic [CNT_W-1:0] shadow_limit;

  // Lookup results still owed by the block, oldest first.
  lookup_res_t pending_lookups[$];
  lookup_res_t got_res;
  lookup_res_t exp_res;

  int errors;
  int items_sent;
  int results_checked;
  int hit_cnt;
  int move_cnt;
  int drop_cnt;
  int wrap_cnt;
  int limit_writes;

  // Predicted outcome of one key transaction; updates the shadow table.
  function automatic lookup_res_t lookup_and_count(input logic [KEY_W-1:0] key);
    lookup_res_t      r;
    int               b;
    int               pos;
    int               fill;
    logic             hit;
    logic [CNT_W-1:0] cnt;
    r    = '0;
    b    = key % NB;
    fill = shadow_fill[b];
    pos  = 0;
    hit  = 1'b0;
    cnt  = '0;
    // front-to-back search, first match wins
    for (int i = 0; i < fill; i++) begin
      if (!hit && shadow_key[b][i] == key) begin
        hit = 1'b1;
        pos = i;
      end
    end
    if (hit) begin
      hit_cnt++;
      if (shadow_cnt[b][pos] == '1) wrap_cnt++;
      cnt = shadow_cnt[b][pos] + 1'b1;  // 4-bit count wraps 15 -> 0
      if (cnt == shadow_limit) begin
        cnt = '0;
        if (pos > 0) begin
          // entries ahead of the hit slide back one slot
          for (int i = pos; i > 0; i--) begin
            shadow_key[b][i] = shadow_key[b][i-1];
            shadow_cnt[b][i] = shadow_cnt[b][i-1];
          end
          shadow_key[b][0] = key;
          shadow_cnt[b][0] = '0;
          r.moved_front    = 1'b1;
          move_cnt++;
        end else begin
          shadow_cnt[b][0] = '0;  // already at the head: reset only
        end
      end else begin
        shadow_cnt[b][pos] = cnt;
      end
    end else if (fill < ND) begin
      pos              = fill;
      shadow_key[b][pos] = key;
      shadow_cnt[b][pos] = '0;
      shadow_fill[b]     = fill + 1;
    end else begin
      r.full_drop = 1'b1;  // row full, table left alone
      pos         = 0;
      drop_cnt++;
    end
    r.bucket      = BUCKET_OW'(b);
    r.found       = hit;
    r.count_after = cnt;
    r.position    = POS_OW'(pos);
    return r;
  endfunction

  task automatic report_error(input string what, input lookup_res_t exp,
                              input lookup_res_t act);
    errors++;
    if (errors <= 10) begin
      $display("ERR %0t %s: exp b=%0d f=%0d c=%0d p=%0d m=%0d d=%0d",
               $realtime, what, exp.bucket, exp.found, exp.count_after, exp.position,
               exp.moved_front, exp.full_drop);
      $display("    got b=%0d f=%0d c=%0d p=%0d m=%0d d=%0d",
               act.bucket, act.found, act.count_after, act.position,
               act.moved_front, act.full_drop);
    end
  endtask

  // Result checker: every strobed result is matched to the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      got_res = {out_bucket, out_found, out_count_after, out_position,
                 out_moved_front, out_full_drop};
      if (pending_lookups.size() == 0) begin
        report_error("result with nothing pending", '0, got_res);
      end else begin
        exp_res = pending_lookups.pop_front();
        results_checked++;
        if (got_res !== exp_res) report_error("result mismatch", exp_res, got_res);
      end
    end
  end

  // Send one key. Called at a falling edge; returns at a falling edge with
  // start still high so back-to-back transactions need not drop it.
  task automatic send_key(input logic [KEY_W-1:0] key);
    start  = 1'b1;
    in_key = key;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_lookups.push_back(lookup_and_count(key));
    items_sent++;
    @(negedge clk);
  endtask

  // Sender idles with start low for the requested gap (no-op for zero so start is not toggled).
  task automatic pause_tx(input int n);
    if (n > 0) begin
      start = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Wait until every predicted result has come back, plus a latency cushion.
  task automatic wait_idle();
    int guard;
    guard = 0;
    start = 1'b0;
    while (pending_lookups.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (LAT_CUSHION) @(posedge clk);
    @(negedge clk);
  endtask

  // count_limit write, only with the block idle.
  task automatic write_limit(input logic [CNT_W-1:0] v);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_data  = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_limit = v;
    limit_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly short gaps, a few long ones.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A key currently held somewhere in the table.
  function automatic logic [KEY_W-1:0] pick_stored_key();
    int b;
    b = $urandom_range(0, NB - 1);
    while (shadow_fill[b] == 0) b = (b + 1) % NB;
    return shadow_key[b][$urandom_range(0, shadow_fill[b] - 1)];
  endfunction

  // Reset limit (10): appends of the key extremes into each bucket, one hit.
  task automatic test_basic_insert();
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'h8000_0000);
    send_key(32'h7FFF_FFFF);
    send_key(32'h5555_5555);
    send_key(32'hAAAA_AAAA);
    send_key(32'hFFFF_FFFF);
  endtask

  // Limit 1: every hit reaches the limit. Non-head hits move to the head,
  // a head hit only clears its count.
  task automatic test_move_to_head();
    write_limit(4'd1);
    send_key(32'h8000_0000);
    send_key(32'h8000_0000);
    send_key(32'h0000_0000);
  endtask

  // Fill bucket 1 to its depth, drop a new key, then move the tail to the head.
  task automatic test_full_bucket();
    logic [KEY_W-1:0] tail_key;
    write_limit(4'd1);
    send_key(32'h0000_0001);
    send_key(32'hFFFF_FFFD);
    for (int i = 0; i < 5; i++) begin
      tail_key = {30'($urandom_range(0, 32'h3FFF_FFFF)), 2'b01};
      tail_key[31] = i[0];
      send_key(tail_key);
    end
    send_key(32'h1234_5679);
    send_key(tail_key);
  endtask

  // Limit extremes: 15, then 0 (only a wrap of the count can reach it).
  task automatic test_limit_extremes();
    write_limit(4'd15);
    send_key(32'hAAAA_AAAA);
    write_limit(4'd0);
    send_key(32'hAAAA_AAAA);
    send_key(32'h7FFF_FFFF);
  endtask

  // Random traffic in phases, one count_limit per phase. Most transactions
  // re-hit stored keys in bursts so counts climb to the limit (and past it
  // after the limit drops); the rest are fresh keys that append or drop.
  task automatic test_random_traffic();
    logic [CNT_W-1:0] lim;
    logic [KEY_W-1:0] key;
    int               sent;
    int               run;
    int               sel;
    bit               gaps_on;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       lim = 4'd15;
        1:       lim = 4'd2;   // counts left high by 15 climb and wrap
        2:       lim = 4'd0;
        3:       lim = 4'd1;
        default: lim = CNT_W'($urandom_range(0, 15));
      endcase
      write_limit(lim);
      gaps_on = ($urandom_range(0, 3) != 0);  // some phases run flat out
      sent    = 0;
      while (sent < PHASE_ITEMS) begin
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
          key = $urandom;
          run = 1;
        end else begin
          key = pick_stored_key();
          run = (sel < 70) ? $urandom_range(2, 18) : 1;
        end
        for (int k = 0; k < run && sent < PHASE_ITEMS; k++) begin
          send_key(key);
          sent++;
          if (gaps_on) pause_tx(draw_gap());
        end
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_key          = '0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    shadow_limit    = LIMIT_RESET;
    errors          = 0;
    items_sent      = 0;
    results_checked = 0;
    hit_cnt         = 0;
    move_cnt        = 0;
    drop_cnt        = 0;
    wrap_cnt        = 0;
    limit_writes    = 0;
    for (int b = 0; b < NB; b++) shadow_fill[b] = 0;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_basic_insert();
    test_move_to_head();
    test_full_bucket();
    test_limit_extremes();
    test_random_traffic();

    wait_idle();
    if (pending_lookups.size() != 0) begin
      $display("ERR %0d predicted results never arrived", pending_lookups.size());
      errors += pending_lookups.size();
    end

    $display("Run covered %0d keys (%0d checked) over %0d count_limit writes",
             items_sent, results_checked, limit_writes);
    $display("  hits %0d, moves to head %0d, full-row drops %0d, count wraps %0d",
             hit_cnt, move_cnt, drop_cnt, wrap_cnt);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
